### rtl/cursor_linked_list_engine_assert.svh
// Assertion macros shared by the engine's modules.
// Each macro is a concurrent assertion clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
`ifndef CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define CLLE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CLLE_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CLLE_ASSERT(label, clk, rstn, prop, msg)
`define CLLE_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

### rtl/clle_pkg.sv
package clle_pkg;

    localparam int CELLS  = 1024;
    localparam int AW     = $clog2(CELLS);
    localparam int SW     = AW + 1;
    localparam int DW     = 32;
    localparam int CW     = 10;
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [CW-1:0] CNT_MAX = '1;

    localparam logic [3:0] FN_CREATE  = 4'd0;
    localparam logic [3:0] FN_INSERT  = 4'd1;
    localparam logic [3:0] FN_APPEND  = 4'd2;
    localparam logic [3:0] FN_DELETE  = 4'd3;
    localparam logic [3:0] FN_FIND    = 4'd4;
    localparam logic [3:0] FN_LENGTH  = 4'd5;
    localparam logic [3:0] FN_REVERSE = 4'd6;
    localparam logic [3:0] FN_CLEAR   = 4'd7;
    localparam logic [3:0] FN_DESTROY = 4'd8;
    localparam logic [3:0] FN_READ    = 4'd9;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef enum logic [3:0] {
        OP_CREATE, OP_INSERT, OP_APPEND, OP_DELETE, OP_FIND,
        OP_LENGTH, OP_REVERSE, OP_CLEAR, OP_DESTROY, OP_READ, OP_NOP
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [AW-1:0]   head;
        logic [AW-1:0]   pos;
        logic [DW-1:0]   value;
    } t_cmd;

endpackage

### rtl/cursor_linked_list_engine.sv
// Walks: find and delete walk the list until a match; append, length, reverse, clear and
// destroy walk the whole list; read_node, create and insert_after do not walk the list.
// One memory read port sets the walk rate.
// Throughput: one word at a time in the executor, a two-entry queue takes words ahead.
// Reset (synchronous, active low) starts a pass over every cell that rebuilds the free list
// and clears all values; busy stays high through it. Results cannot be stalled.
module cursor_linked_list_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_func,
    input  logic [9:0]         i_list_head,
    input  logic [9:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               strobe,
    output logic [9:0]         o_result_position,
    output logic signed [31:0] o_value_out,
    output logic [9:0]         o_count,
    output logic [1:0]         o_status
);

    // The front end decodes each accepted word into an operation and queues it.
    // The executor owns the cell memories and runs one operation at a time,
    // walking a list one cell per clock where the operation needs a walk.

    logic            f_busy;
    logic            q_valid;
    clle_pkg::t_cmd  q_cmd;
    logic            pop;
    logic            init;
    logic [31:0]     rval;

    clle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_func      (i_func),
        .i_list_head (i_list_head),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_hold      (init),
        .i_pop       (pop),
        .o_busy      (f_busy),
        .o_valid     (q_valid),
        .o_cmd       (q_cmd)
    );

    clle_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (q_cmd),
        .o_pop    (pop),
        .o_init   (init),
        .o_strobe (strobe),
        .o_rpos   (o_result_position),
        .o_rval   (rval),
        .o_cnt    (o_count),
        .o_status (o_status)
    );

    // Busy covers both a full queue and the clearing pass after reset.
    assign busy        = f_busy;
    assign o_value_out = signed'(rval);

endmodule

### rtl/clle_front.sv
module clle_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [3:0]                i_func,
    input  logic [clle_pkg::AW-1:0]   i_list_head,
    input  logic [clle_pkg::AW-1:0]   i_position,
    input  logic [clle_pkg::DW-1:0]   i_value,
    input  logic                      i_hold,
    input  logic                      i_pop,
    output logic                      o_busy,
    output logic                      o_valid,
    output clle_pkg::t_cmd            o_cmd
);

`include "cursor_linked_list_engine_assert.svh"

    clle_pkg::t_cmd                r_q [clle_pkg::QDEPTH];
    logic [clle_pkg::QAW-1:0]      r_wp;
    logic [clle_pkg::QAW-1:0]      r_rp;
    logic [clle_pkg::QAW:0]        r_cnt;
    clle_pkg::t_op                 op;
    logic                          push;

    // Decode the function code; codes without a meaning become no-ops.
    always_comb begin
        unique case (i_func)
            clle_pkg::FN_CREATE:  op = clle_pkg::OP_CREATE;
            clle_pkg::FN_INSERT:  op = clle_pkg::OP_INSERT;
            clle_pkg::FN_APPEND:  op = clle_pkg::OP_APPEND;
            clle_pkg::FN_DELETE:  op = clle_pkg::OP_DELETE;
            clle_pkg::FN_FIND:    op = clle_pkg::OP_FIND;
            clle_pkg::FN_LENGTH:  op = clle_pkg::OP_LENGTH;
            clle_pkg::FN_REVERSE: op = clle_pkg::OP_REVERSE;
            clle_pkg::FN_CLEAR:   op = clle_pkg::OP_CLEAR;
            clle_pkg::FN_DESTROY: op = clle_pkg::OP_DESTROY;
            clle_pkg::FN_READ:    op = clle_pkg::OP_READ;
            default:              op = clle_pkg::OP_NOP;
        endcase
    end

    assign o_busy  = (r_cnt == (clle_pkg::QAW + 1)'(clle_pkg::QDEPTH)) || i_hold;
    assign push    = i_start && !o_busy;
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: op, head: i_list_head, pos: i_position, value: i_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (clle_pkg::QAW + 1)'(push) - (clle_pkg::QAW + 1)'(i_pop);
        end
    end

    `CLLE_NEVER(a_q_overflow, i_clk, i_rst_n, r_cnt > (clle_pkg::QAW + 1)'(clle_pkg::QDEPTH), "queue overfull")
    `CLLE_NEVER(a_q_underflow, i_clk, i_rst_n, i_pop && (r_cnt == '0), "pop from empty queue")
    `CLLE_ASSERT(a_q_push_seen, i_clk, i_rst_n, push |=> (r_cnt != '0), "accepted word lost")

endmodule

### rtl/clle_exec.sv
module clle_exec (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  clle_pkg::t_cmd            i_cmd,
    output logic                      o_pop,
    output logic                      o_init,
    output logic                      o_strobe,
    output logic [clle_pkg::AW-1:0]   o_rpos,
    output logic [clle_pkg::DW-1:0]   o_rval,
    output logic [clle_pkg::CW-1:0]   o_cnt,
    output logic [1:0]                o_status
);

`include "cursor_linked_list_engine_assert.svh"

    localparam int AW = clle_pkg::AW;
    localparam int SW = clle_pkg::SW;
    localparam int DW = clle_pkg::DW;
    localparam int CW = clle_pkg::CW;
    localparam int CNT_MAX_W = (1 << CW) - 1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_TAKE, S_INS1, S_INS2, S_WALK, S_SFIRST, S_SRCH,
        S_DEL1, S_REV0, S_REV, S_CLR0, S_CLR, S_READ
    } t_state;

    // Cell memories. Link entry 0 is never used: the free-list head lives in r_fhead.
    logic [AW-1:0]  r_link_mem [clle_pkg::CELLS];
    logic [DW-1:0]  r_val_mem  [clle_pkg::CELLS];
    logic [AW-1:0]  r_rl;
    logic [DW-1:0]  r_rv;
    logic [AW-1:0]  r_ra;

    t_state         r_state, n_state;
    clle_pkg::t_op  r_op, n_op;
    logic [AW-1:0]  r_head, n_head;
    logic [AW-1:0]  r_pos, n_pos;
    logic [DW-1:0]  r_val, n_val;
    logic [AW-1:0]  r_cur, n_cur;
    logic [AW-1:0]  r_prev, n_prev;
    logic [AW-1:0]  r_new, n_new;
    logic [SW-1:0]  r_steps, n_steps;
    logic [AW-1:0]  r_fhead, n_fhead;
    logic [AW-1:0]  r_icnt, n_icnt;
    logic           r_strobe, n_strobe;
    logic [AW-1:0]  r_rpos, n_rpos;
    logic [DW-1:0]  r_rval, n_rval;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [1:0]     r_status, n_status;

    logic [AW-1:0]  raddr;
    logic           lw_en;
    logic [AW-1:0]  lw_addr;
    logic [AW-1:0]  lw_data;
    logic           vw_en;
    logic [DW-1:0]  vw_data;
    logic           fh_set;
    logic [AW-1:0]  fh_data;
    logic           mem_we;
    logic [AW-1:0]  rl_sub;
    logic           walk_end;

    // A read of cell 0's link returns the free-list head register.
    assign rl_sub   = (r_ra == '0) ? r_fhead : r_rl;
    assign mem_we   = lw_en && (lw_addr != '0);
    assign walk_end = (r_steps == SW'(clle_pkg::CELLS));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[lw_addr] <= lw_data;
        end
        if (vw_en) begin
            r_val_mem[lw_addr] <= vw_data;
        end
        r_rl <= (mem_we && lw_addr == raddr) ? lw_data : r_link_mem[raddr];
        r_rv <= (vw_en && lw_addr == raddr) ? vw_data : r_val_mem[raddr];
        r_ra <= raddr;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_head   = r_head;
        n_pos    = r_pos;
        n_val    = r_val;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_new    = r_new;
        n_steps  = r_steps;
        n_icnt   = r_icnt;
        n_strobe = 1'b0;
        n_rpos   = '0;
        n_rval   = '0;
        n_cnt    = '0;
        n_status = clle_pkg::ST_OK;
        raddr    = r_cur;
        lw_en    = 1'b0;
        lw_addr  = r_cur;
        lw_data  = '0;
        vw_en    = 1'b0;
        vw_data  = '0;
        fh_set   = 1'b0;
        fh_data  = '0;
        o_pop    = 1'b0;

        unique case (r_state)
            S_INIT: begin
                lw_en   = 1'b1;
                lw_addr = r_icnt;
                lw_data = r_icnt + 1'b1;
                vw_en   = 1'b1;
                n_icnt  = r_icnt + 1'b1;
                if (r_icnt == AW'(clle_pkg::CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_op    = i_cmd.op;
                    n_head  = i_cmd.head;
                    n_pos   = i_cmd.pos;
                    n_val   = i_cmd.value;
                    n_cur   = i_cmd.head;
                    n_prev  = (i_cmd.op == clle_pkg::OP_REVERSE) ? '0 : i_cmd.head;
                    n_new   = r_fhead;
                    n_steps = '0;
                    raddr   = i_cmd.head;
                    unique case (i_cmd.op)
                        clle_pkg::OP_CREATE, clle_pkg::OP_INSERT: begin
                            raddr   = r_fhead;
                            n_state = S_TAKE;
                        end
                        clle_pkg::OP_APPEND, clle_pkg::OP_LENGTH: n_state = S_WALK;
                        clle_pkg::OP_DELETE, clle_pkg::OP_FIND:   n_state = S_SFIRST;
                        clle_pkg::OP_REVERSE:                     n_state = S_REV0;
                        clle_pkg::OP_CLEAR, clle_pkg::OP_DESTROY: n_state = S_CLR0;
                        clle_pkg::OP_READ: begin
                            raddr   = i_cmd.pos;
                            n_state = S_READ;
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            S_TAKE: begin
                if (r_new == '0) begin
                    n_strobe = 1'b1;
                    n_status = clle_pkg::ST_NOSPACE;
                    n_state  = S_IDLE;
                end else begin
                    fh_set  = 1'b1;
                    fh_data = r_rl;
                    if (r_op == clle_pkg::OP_CREATE) begin
                        lw_en    = 1'b1;
                        lw_addr  = r_new;
                        n_strobe = 1'b1;
                        n_rpos   = r_new;
                        n_state  = S_IDLE;
                    end else begin
                        raddr   = r_pos;
                        n_state = S_INS1;
                    end
                end
            end
            S_INS1: begin
                lw_en   = 1'b1;
                lw_addr = r_new;
                lw_data = rl_sub;
                vw_en   = 1'b1;
                vw_data = r_val;
                n_state = S_INS2;
            end
            S_INS2: begin
                lw_en    = 1'b1;
                lw_addr  = r_pos;
                lw_data  = r_new;
                n_strobe = 1'b1;
                n_rpos   = r_new;
                n_state  = S_IDLE;
            end
            S_WALK: begin
                if (rl_sub == '0 || walk_end) begin
                    if (r_op == clle_pkg::OP_LENGTH) begin
                        n_strobe = 1'b1;
                        n_cnt    = (r_steps > SW'(CNT_MAX_W)) ? clle_pkg::CNT_MAX
                                                              : r_steps[CW-1:0];
                        n_state  = S_IDLE;
                    end else begin
                        n_pos   = r_cur;
                        n_new   = r_fhead;
                        raddr   = r_fhead;
                        n_state = S_TAKE;
                    end
                end else begin
                    n_cur   = rl_sub;
                    raddr   = rl_sub;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_SFIRST: begin
                if (rl_sub == '0) begin
                    n_strobe = 1'b1;
                    n_status = clle_pkg::ST_NOTFOUND;
                    n_state  = S_IDLE;
                end else begin
                    n_cur   = rl_sub;
                    raddr   = rl_sub;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_rv == r_val) begin
                    if (r_op == clle_pkg::OP_FIND) begin
                        n_strobe = 1'b1;
                        n_rpos   = r_cur;
                        n_state  = S_IDLE;
                    end else begin
                        lw_en   = 1'b1;
                        lw_addr = r_prev;
                        lw_data = rl_sub;
                        n_state = S_DEL1;
                    end
                end else if (walk_end || rl_sub == '0) begin
                    n_strobe = 1'b1;
                    n_status = clle_pkg::ST_NOTFOUND;
                    n_state  = S_IDLE;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = rl_sub;
                    raddr   = rl_sub;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_DEL1: begin
                lw_en    = 1'b1;
                lw_addr  = r_cur;
                lw_data  = r_fhead;
                vw_en    = 1'b1;
                fh_set   = 1'b1;
                fh_data  = r_cur;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_REV0: begin
                n_cur   = rl_sub;
                raddr   = rl_sub;
                n_state = S_REV;
            end
            S_REV: begin
                if (r_cur == '0 || walk_end) begin
                    lw_en    = 1'b1;
                    lw_addr  = r_head;
                    lw_data  = r_prev;
                    n_strobe = 1'b1;
                    n_rpos   = r_head;
                    n_state  = S_IDLE;
                end else begin
                    lw_en   = 1'b1;
                    lw_addr = r_cur;
                    lw_data = r_prev;
                    n_prev  = r_cur;
                    n_cur   = rl_sub;
                    raddr   = rl_sub;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_CLR0: begin
                lw_en   = 1'b1;
                lw_addr = r_head;
                n_cur   = rl_sub;
                raddr   = rl_sub;
                n_state = S_CLR;
            end
            S_CLR: begin
                if (r_cur == '0 || walk_end) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (r_op == clle_pkg::OP_CLEAR) begin
                        n_rpos = r_head;
                    end else if (r_head != '0) begin
                        lw_en   = 1'b1;
                        lw_addr = r_head;
                        lw_data = r_fhead;
                        vw_en   = 1'b1;
                        fh_set  = 1'b1;
                        fh_data = r_head;
                    end
                end else begin
                    lw_en   = 1'b1;
                    lw_addr = r_cur;
                    lw_data = r_fhead;
                    vw_en   = 1'b1;
                    fh_set  = 1'b1;
                    fh_data = r_cur;
                    n_cur   = rl_sub;
                    raddr   = rl_sub;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_READ: begin
                n_strobe = 1'b1;
                n_rpos   = rl_sub;
                n_rval   = r_rv;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (fh_set) begin
            n_fhead = fh_data;
        end else if (lw_en && lw_addr == '0) begin
            n_fhead = lw_data;
        end else begin
            n_fhead = r_fhead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_icnt   <= '0;
            r_fhead  <= AW'(1);
            r_strobe <= 1'b0;
            r_steps  <= '0;
        end else begin
            r_state  <= n_state;
            r_icnt   <= n_icnt;
            r_fhead  <= n_fhead;
            r_strobe <= n_strobe;
            r_steps  <= n_steps;
        end
        r_op     <= n_op;
        r_head   <= n_head;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_new    <= n_new;
        r_rpos   <= n_rpos;
        r_rval   <= n_rval;
        r_cnt    <= n_cnt;
        r_status <= n_status;
    end

    assign o_init   = (r_state == S_INIT);
    assign o_strobe = r_strobe;
    assign o_rpos   = r_rpos;
    assign o_rval   = r_rval;
    assign o_cnt    = r_cnt;
    assign o_status = r_status;

    `CLLE_NEVER(a_no_result_in_init, i_clk, i_rst_n, r_strobe && (r_state == S_INIT), "result during init")
    `CLLE_ASSERT(a_result_ends_op, i_clk, i_rst_n, r_strobe |-> (r_state == S_IDLE), "result without return to idle")
    `CLLE_NEVER(a_walk_bound, i_clk, i_rst_n, r_steps > SW'(clle_pkg::CELLS), "walk past cell count")

endmodule
